// ----- rtl/core/gbw_pkg.sv -----
// Package for the Gaussian blur window: shared constants, register indexes and types.
// Depends on nothing; imported by every module in rtl/core.
package gbw_pkg;

  localparam int unsigned MaxRadius   = 3;
  localparam int unsigned MaxRow      = 1024;
  localparam int unsigned TapFracBits = 15;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned PixW     = 8;
  localparam int unsigned WidthW   = 10;
  localparam int unsigned TapW     = 16;
  localparam int unsigned InvW     = 17;

  typedef enum logic [CfgIdxW-1:0] {
    RegKernelRadius = 3'd0,
    RegOutWidth     = 3'd1,
    RegTapCenter    = 3'd2,
    RegTapDistOne   = 3'd3,
    RegTapDistTwo   = 3'd4,
    RegTapDistThree = 3'd5,
    RegInvKernelSum = 3'd6
  } cfg_reg_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    StIdle, StMac, StMulLo, StMulHi, StRound, StOut
  } back_state_e;

  // Settings the back end needs to compute a result.
  typedef struct packed {
    logic [1:0]        radius;
    logic [TapW-1:0]   tap0;
    logic [TapW-1:0]   tap1;
    logic [TapW-1:0]   tap2;
    logic [TapW-1:0]   tap3;
    logic [InvW-1:0]   inv_sum;
  } arith_cfg_t;

endpackage

// ----- rtl/core/gbw_front.sv -----
// Front end of the Gaussian blur window: line stores, window registers and counters.
// Depends on gbw_pkg. Emits a full window per accepted pixel when an output is due.
module gbw_front #(
  parameter int unsigned MAX_RADIUS = gbw_pkg::MaxRadius,
  parameter int unsigned MAX_ROW    = gbw_pkg::MaxRow
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    restart_i,
  input  logic [1:0]              radius_i,
  input  logic [gbw_pkg::WidthW-1:0] out_width_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [gbw_pkg::PixW-1:0] pixel_i,
  input  logic                    frame_start_i,
  output logic                    win_valid_o,
  input  logic                    win_ready_i,
  output logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*gbw_pkg::PixW-1:0] win_o,
  output logic                    win_last_o
);
  import gbw_pkg::*;

  localparam int unsigned Dim   = 2 * MAX_RADIUS + 1;
  localparam int unsigned Lines = 2 * MAX_RADIUS;
  localparam int unsigned ColW  = $clog2(MAX_ROW + 1);
  localparam int unsigned AdrW  = $clog2(MAX_ROW);
  localparam int unsigned RowW  = $clog2(Lines + 1);
  localparam int unsigned RadW  = $clog2(MAX_RADIUS + 1);

  // Two-phase sequence per pixel: read line stores, then shift and write.
  logic              busy_q, busy_d;
  logic [PixW-1:0]   pix_q;
  logic              fs_q;
  logic [ColW-1:0]   col_cnt_q, col_cnt_d;
  logic [RowW-1:0]   rows_q, rows_d;
  logic [PixW-1:0]   rd_q [Lines];
  logic [PixW-1:0]   win_q [Dim][Dim];
  logic              out_valid_q;
  logic              out_last_q;

  logic [RadW-1:0]   r_eff;
  logic [ColW-1:0]   two_r, w_eff, lim, col;
  logic [ColW-1:0]   ow;

  // Effective geometry from the configuration.
  always_comb begin
    if (ColW'(radius_i) > ColW'(MAX_RADIUS)) r_eff = RadW'(MAX_RADIUS);
    else r_eff = RadW'(radius_i);
    two_r = ColW'({r_eff, 1'b0});
    lim   = ColW'(MAX_ROW) - two_r;
    ow    = ColW'(out_width_i);
    if (ow == '0) w_eff = ColW'(1) + two_r;
    else if (ow > lim) w_eff = lim + two_r;
    else w_eff = ow + two_r;
  end

  // Column in use for the pending pixel.
  logic [ColW-1:0] col_base;
  logic [RowW-1:0] rows_base;
  always_comb begin
    col_base  = fs_q ? '0 : col_cnt_q;
    rows_base = fs_q ? '0 : rows_q;
    col       = (col_base >= w_eff) ? '0 : col_base;
  end

  logic [ColW-1:0] col_in;
  always_comb begin
    col_in = (frame_start_i || col_cnt_q >= w_eff) ? '0 : col_cnt_q;
  end

  assign in_ready_o  = !busy_q && (!out_valid_q || win_ready_i);
  assign win_valid_o = out_valid_q;
  assign win_last_o  = out_last_q;

  // Line store memories, one per line; read when a pixel is taken, written while busy.
  logic [PixW-1:0] mem_q [Lines][MAX_ROW];
  logic [AdrW-1:0] rd_adr, wr_adr;
  assign rd_adr = AdrW'(col_in);
  assign wr_adr = AdrW'(col);

  for (genvar l = 0; l < Lines; l++) begin : g_line
    logic [PixW-1:0] wdata;
    always_comb begin
      if (l + 1 < int'(two_r)) wdata = rd_q[l+1];
      else wdata = pix_q;
    end
    always_ff @(posedge clk_i) begin
      if (in_valid_i && in_ready_o) rd_q[l] <= mem_q[l][rd_adr];
      if (busy_q && (l < int'(two_r))) mem_q[l][wr_adr] <= wdata;
    end
  end

  // Busy flag.
  always_comb begin
    busy_d = busy_q;
    if (in_valid_i && in_ready_o) busy_d = 1'b1;
    else if (busy_q) busy_d = 1'b0;
  end

  // Counter update after the pixel is taken; restart clears the counters.
  always_comb begin
    col_cnt_d = col_cnt_q;
    rows_d    = rows_q;
    if (restart_i) begin
      col_cnt_d = '0;
      rows_d    = '0;
    end else if (busy_q) begin
      col_cnt_d = col + ColW'(1);
      rows_d    = rows_base;
      if (col + ColW'(1) >= w_eff) begin
        col_cnt_d = '0;
        if (ColW'(rows_base) < two_r) rows_d = rows_base + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      col_cnt_q   <= '0;
      rows_q      <= '0;
      out_valid_q <= 1'b0;
      fs_q        <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      col_cnt_q <= col_cnt_d;
      rows_q    <= rows_d;
      if (in_valid_i && in_ready_o) fs_q <= frame_start_i;
      if (busy_q) begin
        out_valid_q <= (ColW'(rows_base) >= two_r) && (col >= two_r);
      end else if (win_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) pix_q <= pixel_i;
    if (busy_q) out_last_q <= (col == w_eff - ColW'(1));
  end

  // Window shift: columns up to the active size shift left, new column enters.
  for (genvar i = 0; i < Dim; i++) begin : g_row
    for (genvar j = 0; j < Dim; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (busy_q) begin
          if (j + 1 < int'(two_r) + 1) win_q[i][j] <= win_q[i][j+1 < Dim ? j+1 : j];
          else if (j == int'(two_r)) begin
            if (i < int'(two_r)) win_q[i][j] <= rd_q[i < Lines ? i : 0];
            else win_q[i][j] <= pix_q;
          end
        end
      end
      assign win_o[(i*Dim+j)*PixW +: PixW] = win_q[i][j];
    end
  end

endmodule

// ----- rtl/core/gbw_fifo.sv -----
// Short queue between the window front end and the arithmetic back end.
// Imports gbw_pkg but takes its data width only from its parameter.
module gbw_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);
  import gbw_pkg::*;

  // Two-entry queue with a pointer per side.
  logic [DATA_W-1:0] mem_q [2];
  logic              wp_q, rp_q;
  logic [1:0]        cnt_q;
  logic              wr_en, rd_en;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wp_q <= ~wp_q;
      if (rd_en) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ----- rtl/core/gbw_back.sv -----
// Back end of the Gaussian blur window: weighted window sum, scaling and rounding.
// Depends on gbw_pkg. One multiply-accumulate per window element, then normalization.
module gbw_back #(
  parameter int unsigned MAX_RADIUS    = gbw_pkg::MaxRadius,
  parameter int unsigned TAP_FRAC_BITS = gbw_pkg::TapFracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gbw_pkg::arith_cfg_t     cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*gbw_pkg::PixW-1:0] win_i,
  input  logic                    last_i,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [gbw_pkg::PixW-1:0] pix_o,
  output logic                    last_o
);
  import gbw_pkg::*;

  localparam int unsigned Dim   = 2 * MAX_RADIUS + 1;
  localparam int unsigned Cells = Dim * Dim;
  localparam int unsigned IdxW  = $clog2(Dim);
  localparam int unsigned RadW  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned SumW  = PixW + 2 * TapW + $clog2(Cells);
  localparam int unsigned Shift = 2 * TAP_FRAC_BITS + 16;
  localparam int unsigned ProdW = SumW + InvW;

  back_state_e       st_q, st_d;
  logic [IdxW-1:0]   i_q, j_q;
  logic [SumW-1:0]   sum_q;
  logic [ProdW-1:0]  acc_q;
  logic [PixW-1:0]   res_q;
  logic              last_q;
  logic [TapW-1:0]   ta_q;
  logic [PixW+TapW-1:0] pa_q;
  logic              pa_v_q;
  logic [RadW-1:0]   r_eff;
  logic [IdxW-1:0]   dmax;

  always_comb begin
    if (cfg_i.radius > 2'(MAX_RADIUS)) r_eff = RadW'(MAX_RADIUS);
    else r_eff = RadW'(cfg_i.radius);
    dmax = IdxW'({r_eff, 1'b0});
  end

  function automatic logic [TapW-1:0] tap_at(input logic [IdxW-1:0] k,
                                             input logic [RadW-1:0] r,
                                             input arith_cfg_t c);
    logic [IdxW:0] d;
    begin
      d = (k > IdxW'(r)) ? {1'b0, k} - (IdxW+1)'(r) : (IdxW+1)'(r) - {1'b0, k};
      unique case (d)
        (IdxW+1)'(0): tap_at = c.tap0;
        (IdxW+1)'(1): tap_at = c.tap1;
        (IdxW+1)'(2): tap_at = c.tap2;
        (IdxW+1)'(3): tap_at = c.tap3;
        default:      tap_at = '0;
      endcase
    end
  endfunction

  // Next state.
  logic mac_done;
  assign mac_done = (i_q == dmax) && (j_q == dmax);
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (in_valid_i) st_d = StMac;
      StMac:   if (mac_done) st_d = StMulLo;
      StMulLo: st_d = StMulHi;
      StMulHi: st_d = StRound;
      StRound: st_d = StOut;
      StOut:   if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // Outputs. The window stays at the queue head until its last element is used.
  always_comb begin
    in_ready_o    = (st_q == StMulLo);
    m_axis_tvalid = (st_q == StOut);
  end
  assign pix_o  = res_q;
  assign last_o = last_q;

  // Two multipliers in series: pixel times column tap, then times row tap.
  logic [TapW-1:0] tb;
  logic [PixW-1:0] cur;
  logic [SumW-1:0] term;
  assign tb  = tap_at(j_q, r_eff, cfg_i);
  assign cur = win_i[(int'(i_q) * Dim + int'(j_q)) * PixW +: PixW];
  assign term = SumW'(pa_q) * SumW'(ta_q);

  logic [ProdW-1:0] rnd;
  logic [ProdW-1:0] rsh;
  assign rnd = acc_q + (ProdW'(1) << (Shift - 1));
  assign rsh = rnd >> Shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        last_q <= last_i;
        i_q    <= '0;
        j_q    <= '0;
        sum_q  <= '0;
        pa_v_q <= 1'b0;
      end
      StMac: begin
        pa_q   <= PixW'(cur) * tb;
        ta_q   <= tap_at(i_q, r_eff, cfg_i);
        pa_v_q <= 1'b1;
        if (pa_v_q) sum_q <= sum_q + term;
        if (j_q == dmax) begin
          j_q <= '0;
          i_q <= i_q + IdxW'(1);
        end else begin
          j_q <= j_q + IdxW'(1);
        end
      end
      StMulLo: begin
        sum_q  <= sum_q + term;
      end
      StMulHi: begin
        acc_q <= ProdW'(sum_q[SumW/2-1:0]) * ProdW'(cfg_i.inv_sum)
               + ((ProdW'(sum_q[SumW-1:SumW/2]) * ProdW'(cfg_i.inv_sum)) << (SumW/2));
      end
      StRound: begin
        res_q <= (rsh > ProdW'(255)) ? 8'hFF : rsh[PixW-1:0];
      end
      StOut: ;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/gaussian_blur_window.sv -----
// Top level of the Gaussian blur window: configuration registers, front, queue, back.
// Depends on gbw_pkg, gbw_front, gbw_fifo and gbw_back.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata = pixel_in[7:0]; tuser = frame_start
//  m_axis    out        tdata = blurred_pixel[7:0]; tlast = end_of_row
//  cfg       in         cfg_index_i[2:0], cfg_data_i[16:0]
//
// Each pixel passes through two phases in the front end (line store read, then write).
// The back end takes one window at a time and does not start the next until its result is sent.
// Reset clears counters and control; line stores hold garbage until written.
// A two-entry queue lets the front keep taking pixels while the back is busy.
module gaussian_blur_window #(
  parameter int unsigned MAX_RADIUS    = gbw_pkg::MaxRadius,
  parameter int unsigned MAX_ROW       = gbw_pkg::MaxRow,
  parameter int unsigned TAP_FRAC_BITS = gbw_pkg::TapFracBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // pixel_in
  input  logic                        s_axis_tuser,  // frame_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // blurred_pixel
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gbw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gbw_pkg::CfgDataW-1:0] cfg_data_i
);
  import gbw_pkg::*;

  localparam int unsigned WinW = (2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*PixW;

  logic [1:0]        radius_q;
  logic [WidthW-1:0] width_q;
  arith_cfg_t        acfg_q;
  logic              restart;
  logic              cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_wr && (cfg_index_i == RegKernelRadius ||
                                  cfg_index_i == RegOutWidth);

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q       <= 2'd1;
      width_q        <= WidthW'(640);
      acfg_q.radius  <= 2'd1;
      acfg_q.tap0    <= TapW'(32768);
      acfg_q.tap1    <= '0;
      acfg_q.tap2    <= '0;
      acfg_q.tap3    <= '0;
      acfg_q.inv_sum <= InvW'(65536);
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        RegKernelRadius: begin
          radius_q      <= cfg_data_i[1:0];
          acfg_q.radius <= cfg_data_i[1:0];
        end
        RegOutWidth:     width_q        <= cfg_data_i[WidthW-1:0];
        RegTapCenter:    acfg_q.tap0    <= cfg_data_i[TapW-1:0];
        RegTapDistOne:   acfg_q.tap1    <= cfg_data_i[TapW-1:0];
        RegTapDistTwo:   acfg_q.tap2    <= cfg_data_i[TapW-1:0];
        RegTapDistThree: acfg_q.tap3    <= cfg_data_i[TapW-1:0];
        RegInvKernelSum: acfg_q.inv_sum <= cfg_data_i[InvW-1:0];
        default: ;
      endcase
    end
  end

  logic            fw_valid, fw_ready, fw_last, bk_valid, bk_ready, bk_last;
  logic [WinW-1:0] fw_win, bk_win;

  gbw_front #(.MAX_RADIUS(MAX_RADIUS), .MAX_ROW(MAX_ROW)) u_front (
    .clk_i, .rst_ni,
    .restart_i     (restart),
    .radius_i      (radius_q),
    .out_width_i   (width_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .win_valid_o   (fw_valid),
    .win_ready_i   (fw_ready),
    .win_o         (fw_win),
    .win_last_o    (fw_last)
  );

  gbw_fifo #(.DATA_W(WinW + 1)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (fw_valid),
    .wr_ready_o (fw_ready),
    .wr_data_i  ({fw_last, fw_win}),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  ({bk_last, bk_win})
  );

  gbw_back #(.MAX_RADIUS(MAX_RADIUS), .TAP_FRAC_BITS(TAP_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .cfg_i         (acfg_q),
    .in_valid_i    (bk_valid),
    .in_ready_o    (bk_ready),
    .win_i         (bk_win),
    .last_i        (bk_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .pix_o         (m_axis_tdata),
    .last_o        (m_axis_tlast)
  );

endmodule
